[rtl/core/nrm_pkg.sv]
// ----------------------------------------------------------------------------
// nrm_pkg
// Shared types and pipeline constants for the 3d vector normalizer.
// ----------------------------------------------------------------------------
package nrm_pkg;

  localparam int unsigned COMP_W      = 32;
  localparam int unsigned SUM_W       = 64;
  localparam int unsigned SQRT_STAGES = 32;
  localparam int unsigned DIV_STAGES  = 31;
  localparam int unsigned HEAD_STAGES = 2;
  localparam int unsigned PIPE_DEPTH  = HEAD_STAGES + SQRT_STAGES + DIV_STAGES;
  localparam int unsigned LANES       = 3;

  typedef struct packed {
    logic signed [COMP_W-1:0] comp_x;
    logic signed [COMP_W-1:0] comp_y;
    logic signed [COMP_W-1:0] comp_z;
  } nrm_in_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] unit_x;
    logic signed [COMP_W-1:0] unit_y;
    logic signed [COMP_W-1:0] unit_z;
    logic        [COMP_W-1:0] length;
    logic                     zero_vector;
  } nrm_out_t;

endpackage

[rtl/core/nrm_sqrt.sv]
// ----------------------------------------------------------------------------
// nrm_sqrt
// Pipelined floor square root of a 64-bit value, one root bit per stage.
// ----------------------------------------------------------------------------
module nrm_sqrt (
  input  logic                       clk,
  input  logic                       en,
  input  logic [nrm_pkg::SUM_W-1:0]  sum_i,
  output logic [nrm_pkg::COMP_W-1:0] root_o
);
  import nrm_pkg::*;

  logic [SUM_W-1:0]  s_r    [SQRT_STAGES];
  logic [33:0]       rem_r  [SQRT_STAGES];
  logic [COMP_W-1:0] root_r [SQRT_STAGES];
  logic [SUM_W-1:0]  s_nxt    [SQRT_STAGES];
  logic [33:0]       rem_nxt  [SQRT_STAGES];
  logic [COMP_W-1:0] root_nxt [SQRT_STAGES];

  always_comb begin
    logic [SUM_W-1:0]  s_in;
    logic [33:0]       rem_in;
    logic [COMP_W-1:0] root_in;
    logic [35:0]       remx;
    logic [35:0]       trial;
    for (int k = 0; k < SQRT_STAGES; k++) begin
      if (k == 0) begin
        s_in    = sum_i;
        rem_in  = '0;
        root_in = '0;
      end else begin
        s_in    = s_r[k-1];
        rem_in  = rem_r[k-1];
        root_in = root_r[k-1];
      end
      // bring down the next two radicand bits
      remx  = {rem_in, s_in[SUM_W-1 -: 2]};
      trial = {2'b00, root_in, 2'b01};
      s_nxt[k] = {s_in[SUM_W-3:0], 2'b00};
      if (remx >= trial) begin
        rem_nxt[k]  = 34'(remx - trial);
        root_nxt[k] = {root_in[COMP_W-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = remx[33:0];
        root_nxt[k] = {root_in[COMP_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SQRT_STAGES; k++) begin
        s_r[k]    <= s_nxt[k];
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
      end
    end
  end

  assign root_o = root_r[SQRT_STAGES-1];

endmodule

[rtl/core/nrm_div_lane.sv]
// ----------------------------------------------------------------------------
// nrm_div_lane
// One lane: pipelined restoring divide of |comp| * 2^30 by the length,
// one quotient bit per stage, sign applied at the end.
// ----------------------------------------------------------------------------
module nrm_div_lane (
  input  logic                              clk,
  input  logic                              en,
  input  logic        [nrm_pkg::COMP_W-1:0] mag_i,
  input  logic                              neg_i,
  input  logic        [nrm_pkg::COMP_W-1:0] len_i,
  output logic signed [nrm_pkg::COMP_W-1:0] unit_o
);
  import nrm_pkg::*;

  logic [COMP_W-1:0]     rem_r [DIV_STAGES];
  logic [DIV_STAGES-1:0] q_r   [DIV_STAGES];
  logic [COMP_W-1:0]     len_r [DIV_STAGES];
  logic                  neg_r [DIV_STAGES];
  logic [COMP_W-1:0]     rem_nxt [DIV_STAGES];
  logic [DIV_STAGES-1:0] q_nxt   [DIV_STAGES];

  always_comb begin
    logic [COMP_W:0]       remx;
    logic [COMP_W-1:0]     len_in;
    logic [DIV_STAGES-1:0] q_in;
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (k == 0) begin
        // the first partial remainder is the magnitude itself
        remx   = {1'b0, mag_i};
        len_in = len_i;
        q_in   = '0;
      end else begin
        remx   = {rem_r[k-1], 1'b0};
        len_in = len_r[k-1];
        q_in   = q_r[k-1];
      end
      if (remx >= {1'b0, len_in}) begin
        rem_nxt[k] = COMP_W'(remx - {1'b0, len_in});
        q_nxt[k]   = {q_in[DIV_STAGES-2:0], 1'b1};
      end else begin
        rem_nxt[k] = remx[COMP_W-1:0];
        q_nxt[k]   = {q_in[DIV_STAGES-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        rem_r[k] <= rem_nxt[k];
        q_r[k]   <= q_nxt[k];
        len_r[k] <= (k == 0) ? len_i : len_r[k-1];
        neg_r[k] <= (k == 0) ? neg_i : neg_r[k-1];
      end
    end
  end

  always_comb begin
    logic [COMP_W-1:0] qx;
    qx = {{(COMP_W-DIV_STAGES){1'b0}}, q_r[DIV_STAGES-1]};
    unit_o = neg_r[DIV_STAGES-1] ? signed'(COMP_W'(~qx + 1'b1)) : signed'(qx);
  end

endmodule

[rtl/core/vector3_normalize.sv]
// ----------------------------------------------------------------------------
// vector3_normalize
// Fixed-point 3d vector normalizer: Q16.16 in, magnitude and Q2.30 unit out.
// ----------------------------------------------------------------------------
//  channel | ports                        | payload
//  input   | in_valid, in_ready, in_data  | nrm_in_t  (comp_x/y/z)
//  output  | out_valid, out_ready, out_data | nrm_out_t (unit_x/y/z, length, zero_vector)
//
//  one transaction per cycle unless the output stalls; stages are absolute value and
//  squares, the sum, 32 square root stages, 31 divide stages per lane and
//  the output register. reset clears the valid bits only. the pipeline moves
//  whenever its last stage is empty or the output register is free, so a
//  stalled result does not block input until the last stage fills.
// ----------------------------------------------------------------------------
module vector3_normalize (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  nrm_pkg::nrm_in_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output nrm_pkg::nrm_out_t out_data
);
  import nrm_pkg::*;

  logic [PIPE_DEPTH-1:0] vld_r, vld_nxt;
  logic                  out_valid_r, out_valid_nxt;
  nrm_out_t              out_data_r;
  logic                  en;

  logic signed [COMP_W-1:0] comp [LANES];
  logic [COMP_W-1:0] mag_a_r [LANES];
  logic              neg_a_r [LANES];
  logic [SUM_W-1:0]  sq_a_r  [LANES];
  logic [COMP_W-1:0] mag_b_r [LANES];
  logic              neg_b_r [LANES];
  logic [SUM_W-1:0]  sum_b_r;
  logic [COMP_W-1:0] mag_d_r [SQRT_STAGES][LANES];
  logic              neg_d_r [SQRT_STAGES][LANES];
  logic [COMP_W-1:0] len_d_r [DIV_STAGES];
  logic [COMP_W-1:0] root;
  logic signed [COMP_W-1:0] unit [LANES];

  assign en       = !vld_r[PIPE_DEPTH-1] || !out_valid_r || out_ready;
  assign in_ready = en;

  assign comp[0] = in_data.comp_x;
  assign comp[1] = in_data.comp_y;
  assign comp[2] = in_data.comp_z;

  // lanes: absolute value and square
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        logic [COMP_W-1:0] m;
        m = comp[l][COMP_W-1] ? COMP_W'(~comp[l] + 1'b1) : COMP_W'(comp[l]);
        mag_a_r[l] <= m;
        neg_a_r[l] <= comp[l][COMP_W-1];
        sq_a_r[l]  <= SUM_W'(m) * SUM_W'(m);
      end
      sum_b_r <= sq_a_r[0] + sq_a_r[1] + sq_a_r[2];
      for (int l = 0; l < LANES; l++) begin
        mag_b_r[l] <= mag_a_r[l];
        neg_b_r[l] <= neg_a_r[l];
      end
      // side data follows the square root stages
      for (int k = 0; k < SQRT_STAGES; k++) begin
        for (int l = 0; l < LANES; l++) begin
          mag_d_r[k][l] <= (k == 0) ? mag_b_r[l] : mag_d_r[k-1][l];
          neg_d_r[k][l] <= (k == 0) ? neg_b_r[l] : neg_d_r[k-1][l];
        end
      end
      for (int k = 0; k < DIV_STAGES; k++) begin
        len_d_r[k] <= (k == 0) ? root : len_d_r[k-1];
      end
    end
  end

  nrm_sqrt u_sqrt (
    .clk    (clk),
    .en     (en),
    .sum_i  (sum_b_r),
    .root_o (root)
  );

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    nrm_div_lane u_div (
      .clk    (clk),
      .en     (en),
      .mag_i  (mag_d_r[SQRT_STAGES-1][g]),
      .neg_i  (neg_d_r[SQRT_STAGES-1][g]),
      .len_i  (root),
      .unit_o (unit[g])
    );
  end

  always_comb begin
    vld_nxt = vld_r;
    if (en) begin
      vld_nxt = {vld_r[PIPE_DEPTH-2:0], in_valid};
    end
    out_valid_nxt = out_valid_r;
    if (out_ready || !out_valid_r) begin
      out_valid_nxt = 1'b0;
    end
    if (en && vld_r[PIPE_DEPTH-1]) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // merge: the zero vector skips the scaling
  always_ff @(posedge clk) begin
    if (en && vld_r[PIPE_DEPTH-1]) begin
      logic z;
      z = (len_d_r[DIV_STAGES-1] == '0);
      out_data_r.unit_x      <= z ? '0 : unit[0];
      out_data_r.unit_y      <= z ? '0 : unit[1];
      out_data_r.unit_z      <= z ? '0 : unit[2];
      out_data_r.length      <= len_d_r[DIV_STAGES-1];
      out_data_r.zero_vector <= z;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled while output register free");

  a_zero_units: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.zero_vector |->
      out_data.unit_x == '0 && out_data.unit_y == '0 && out_data.unit_z == '0
      && out_data.length == '0)
    else $error("zero vector with nonzero fields");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.unit_x <= 32'sd1073741824
      && out_data.unit_x >= -32'sd1073741824
      && out_data.unit_y <= 32'sd1073741824
      && out_data.unit_y >= -32'sd1073741824)
    else $error("unit component out of range");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives Q16.16 vectors into the normalizer, predicts magnitude and unit
// components with an independent integer square root and divide, and checks
// every result transaction in order under random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import nrm_pkg::*;

  localparam int LATENCY    = 66;
  localparam int WDOG_LIMIT = 20000;
  localparam int N_RANDOM   = 930;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  nrm_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  nrm_out_t out_data;

  nrm_out_t unit_q[$];
  int       err_cnt = 0;
  int       idle_cnt = 0;
  int       in_idle_pct = 0;
  int       out_idle_pct = 0;

  // directed vectors; expected result typed in where it is obvious
  typedef struct {
    nrm_in_t  vec;
    bit       has_exp;
    nrm_out_t exp;
  } dir_row_t;

  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] UNIT = 32'h4000_0000;
  localparam logic [31:0] MIN = 32'h8000_0000;
  localparam logic [31:0] MAX = 32'h7fff_ffff;

  dir_row_t dir_tbl[] = '{
    '{'{0, 0, 0}, 1, '{0, 0, 0, 0, 1'b1}},
    '{'{ONE, 0, 0}, 1, '{UNIT, 0, 0, ONE, 1'b0}},
    '{'{0, -ONE, 0}, 1, '{0, -UNIT, 0, ONE, 1'b0}},
    '{'{0, 0, ONE}, 1, '{0, 0, UNIT, ONE, 1'b0}},
    '{'{MIN, 0, 0}, 1, '{-UNIT, 0, 0, MIN, 1'b0}},
    '{'{0, MIN, 0}, 0, '{0, 0, 0, 0, 0}},
    '{'{0, 0, MIN}, 0, '{0, 0, 0, 0, 0}},
    '{'{MIN, MIN, MIN}, 0, '{0, 0, 0, 0, 0}},
    '{'{MAX, MAX, MAX}, 0, '{0, 0, 0, 0, 0}},
    '{'{MAX, MIN, MAX}, 0, '{0, 0, 0, 0, 0}},
    '{'{1, 0, 0}, 1, '{UNIT, 0, 0, 1, 1'b0}},
    '{'{-1, -1, -1}, 0, '{0, 0, 0, 0, 0}},
    '{'{1, 1, 1}, 0, '{0, 0, 0, 0, 0}},
    '{'{3 * ONE, 4 * ONE, 0}, 0, '{0, 0, 0, 0, 0}},
    '{'{-2 * ONE, 3 * ONE, -6 * ONE}, 0, '{0, 0, 0, 0, 0}},
    '{'{MAX, 0, 0}, 0, '{0, 0, 0, 0, 0}},
    '{'{32'h5555_5555, 32'haaaa_aaaa, 32'h1234_5678}, 0, '{0, 0, 0, 0, 0}},
    '{'{0, 0, 0}, 1, '{0, 0, 0, 0, 1'b1}}
  };

  vector3_normalize DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] floor_sqrt(input logic [63:0] s);
    logic [63:0] root;
    logic [63:0] trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= s) root = trial;
    end
    return root;
  endfunction

  function automatic nrm_out_t normalize(input nrm_in_t v);
    nrm_out_t r;
    logic [31:0] comp[3];
    logic [63:0] mag[3];
    logic [63:0] sumsq;
    logic [63:0] len;
    logic [63:0] quo[3];
    comp[0] = v.comp_x;
    comp[1] = v.comp_y;
    comp[2] = v.comp_z;
    sumsq = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = comp[i][31] ? {32'd0, -comp[i]} : {32'd0, comp[i]};
      sumsq += mag[i] * mag[i];
    end
    len = floor_sqrt(sumsq);
    for (int i = 0; i < 3; i++) begin
      quo[i] = 0;
      if (len != 0) begin
        quo[i] = (mag[i] << 30) / len;
        if (comp[i][31]) quo[i] = -quo[i];
      end
    end
    r.unit_x = quo[0][31:0];
    r.unit_y = quo[1][31:0];
    r.unit_z = quo[2][31:0];
    r.length = len[31:0];
    r.zero_vector = (len == 0);
    return r;
  endfunction

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 3) == 0 ? MIN : MAX;
      1: return $urandom_range(0, 1) ? 0 : 32'($urandom_range(0, 4)) - 2;
      2: return $signed($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000;
      default: return $urandom;
    endcase
  endfunction

  // exercise the pipeline: input side, valid stays up between transactions unless a random idle is drawn
  task automatic send_vector(input nrm_in_t v, input nrm_out_t exp, input bit has_exp);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= v;
    unit_q.push_back(has_exp ? exp : normalize(v));
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic run_phase(input int n, input int in_pct, input int out_pct);
    nrm_in_t v;
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    for (int k = 0; k < n; k++) begin
      v.comp_x = rand_comp();
      v.comp_y = rand_comp();
      v.comp_z = rand_comp();
      if ($urandom_range(0, 19) == 0) v = '0;
      send_vector(v, '0, 1'b0);
    end
  endtask

  // result side: random stall, compare against oldest expectation
  always @(posedge clk) begin
    nrm_out_t exp;
    if (rst_n && out_valid && out_ready) begin
      if (unit_q.size() == 0) begin
        $error("unexpected result transaction");
        err_cnt++;
      end else begin
        exp = unit_q.pop_front();
        if (out_data.unit_x !== exp.unit_x) begin
          $error("unit_x exp %h got %h", exp.unit_x, out_data.unit_x); err_cnt++;
        end
        if (out_data.unit_y !== exp.unit_y) begin
          $error("unit_y exp %h got %h", exp.unit_y, out_data.unit_y); err_cnt++;
        end
        if (out_data.unit_z !== exp.unit_z) begin
          $error("unit_z exp %h got %h", exp.unit_z, out_data.unit_z); err_cnt++;
        end
        if (out_data.length !== exp.length) begin
          $error("length exp %h got %h", exp.length, out_data.length); err_cnt++;
        end
        if (out_data.zero_vector !== exp.zero_vector) begin
          $error("zero_vector exp %b got %b", exp.zero_vector, out_data.zero_vector);
          err_cnt++;
        end
      end
    end
    out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (rst_n && idle_cnt >= WDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_tbl[i]) send_vector(dir_tbl[i].vec, dir_tbl[i].exp, dir_tbl[i].has_exp);
    run_phase(N_RANDOM / 3, 31, 68);
    run_phase(N_RANDOM / 3, 68, 31);
    run_phase(N_RANDOM / 3, 0, 0);
    in_valid <= 1'b0;
    while (unit_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    if (err_cnt == 0 && unit_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
